FILE: hdl/lhs_pkg.sv
package lhs_pkg;

   localparam int PIXEL_WIDTH = 8;
   localparam int DIV_STEPS = 8;
   localparam int STEP_COUNT_WIDTH = $clog2(DIV_STEPS);
   localparam int PRODUCT_WIDTH = 2 * PIXEL_WIDTH;

   localparam logic [PIXEL_WIDTH-1:0] FULL_SCALE = 8'd255;
   localparam logic [PIXEL_WIDTH-1:0] MIN_RESET = 8'd255;
   localparam logic [PIXEL_WIDTH-1:0] MAX_RESET = 8'd0;

   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_MAP = 1'b1;

   localparam logic [STEP_COUNT_WIDTH-1:0] LAST_STEP = STEP_COUNT_WIDTH'(DIV_STEPS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_WRITE
   } lhs_state_type;

   typedef struct packed {
      logic accumulate;
      logic map_load;
      logic setup;
      logic div_step;
      logic load_out;
   } lhs_cmd_type;

   typedef struct packed {
      logic special;
      logic out_free;
   } lhs_status_type;

endpackage

FILE: hdl/lhs_req_if.sv
interface lhs_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic       starts_frame;
   logic [7:0] pixel;

   modport source (output valid, output operation, output starts_frame, output pixel,
                   input ready);
   modport sink (input valid, input operation, input starts_frame, input pixel,
                 output ready);
endinterface

FILE: hdl/lhs_rsp_if.sv
interface lhs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] stretched_pixel;

   modport source (output valid, output stretched_pixel, input ready);
   modport sink (input valid, input stretched_pixel, output ready);
endinterface

FILE: hdl/lhs_ctrl.sv
module lhs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_operation,
   output logic                   req_ready,
   input  lhs_pkg::lhs_status_type status,
   output lhs_pkg::lhs_cmd_type    cmd
);

   lhs_pkg::lhs_state_type state_ff, state_in;
   logic [lhs_pkg::STEP_COUNT_WIDTH-1:0] count_ff, count_in;
   logic accept;

   assign accept = req_valid && (state_ff == lhs_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lhs_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         lhs_pkg::ST_IDLE: begin
            if (accept && req_operation == lhs_pkg::OP_MAP) begin
               state_in = lhs_pkg::ST_SETUP;
            end
         end
         lhs_pkg::ST_SETUP: begin
            count_in = '0;
            state_in = status.special ? lhs_pkg::ST_WRITE : lhs_pkg::ST_DIVIDE;
         end
         lhs_pkg::ST_DIVIDE: begin
            count_in = count_ff + 1'b1;
            if (count_ff == lhs_pkg::LAST_STEP) begin
               state_in = lhs_pkg::ST_WRITE;
            end
         end
         lhs_pkg::ST_WRITE: begin
            if (status.out_free) begin
               state_in = lhs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lhs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd = '0;
      case (state_ff)
         lhs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.accumulate = accept && req_operation == lhs_pkg::OP_ACCUMULATE;
            cmd.map_load = accept && req_operation == lhs_pkg::OP_MAP;
         end
         lhs_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         lhs_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         lhs_pkg::ST_WRITE: begin
            cmd.load_out = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_last_step_writes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lhs_pkg::ST_DIVIDE && count_ff == lhs_pkg::LAST_STEP)
      |=> state_ff == lhs_pkg::ST_WRITE)
      else $error("division did not end after the last step");
   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result loaded into a full output register");
`endif

endmodule

FILE: hdl/lhs_datapath.sv
module lhs_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_starts_frame,
   input  logic [7:0]             req_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_stretched_pixel,
   input  lhs_pkg::lhs_cmd_type    cmd,
   output lhs_pkg::lhs_status_type status
);

   localparam int W = lhs_pkg::PIXEL_WIDTH;
   localparam int PW = lhs_pkg::PRODUCT_WIDTH;

   logic [W-1:0] min_ff, min_in, max_ff, max_in;
   logic [W-1:0] pixel_ff, pixel_in;
   logic [PW-1:0] rem_ff, rem_in, div_ff, div_in;
   logic [W-1:0] quo_ff, quo_in;
   logic special_ff, special_in;
   logic [W-1:0] spec_val_ff, spec_val_in;
   logic out_valid_ff, out_valid_in;
   logic [W-1:0] out_data_ff, out_data_in;

   logic [W-1:0] base_min, base_max, diff, den;
   logic flat, below, sat, take;
   logic [PW-1:0] rem_sub;

   always_comb begin
      base_min = req_starts_frame ? lhs_pkg::MIN_RESET : min_ff;
      base_max = req_starts_frame ? lhs_pkg::MAX_RESET : max_ff;
      min_in = min_ff;
      max_in = max_ff;
      if (cmd.accumulate) begin
         min_in = (req_pixel < base_min) ? req_pixel : base_min;
         max_in = (req_pixel > base_max) ? req_pixel : base_max;
      end
   end

   always_comb begin
      diff = pixel_ff - min_ff;
      den = max_ff - min_ff;
      flat = (max_ff <= min_ff);
      below = (pixel_ff < min_ff);
      sat = (diff >= den);
      status.special = flat || below || sat;
      status.out_free = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      pixel_in = cmd.map_load ? req_pixel : pixel_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      quo_in = quo_ff;
      special_in = special_ff;
      spec_val_in = spec_val_ff;
      rem_sub = rem_ff - div_ff;
      take = (rem_ff >= div_ff);
      if (cmd.setup) begin
         rem_in = {diff, {W{1'b0}}} - {{W{1'b0}}, diff};
         div_in = {1'b0, den, {(W-1){1'b0}}};
         quo_in = '0;
         special_in = status.special;
         if (flat) begin
            spec_val_in = pixel_ff;
         end else if (below) begin
            spec_val_in = '0;
         end else begin
            spec_val_in = lhs_pkg::FULL_SCALE;
         end
      end else if (cmd.div_step) begin
         if (take) begin
            rem_in = rem_sub;
         end
         div_in = {1'b0, div_ff[PW-1:1]};
         quo_in = {quo_ff[W-2:0], take};
      end
   end

   always_comb begin
      out_data_in = out_data_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.load_out) begin
         out_data_in = special_ff ? spec_val_ff : quo_ff;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= lhs_pkg::MIN_RESET;
         max_ff <= lhs_pkg::MAX_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      special_ff <= special_in;
      spec_val_ff <= spec_val_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_stretched_pixel = out_data_ff;

`ifndef SYNTHESIS
   a_range_ordered: assert property (@(posedge clock) disable iff (reset)
      cmd.accumulate |=> min_ff <= max_ff)
      else $error("minimum above maximum after an accumulated item");
   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> {1'b0, rem_ff} < {div_ff, 1'b0})
      else $error("division remainder out of range");
`endif

endmodule

FILE: hdl/linear_histogram_stretch_top.sv
// Channel   Direction  Payload
// req_ch    in         operation, starts_frame, pixel
// rsp_ch    out        stretched_pixel (one item per map item, none per accumulate item)
//
// An accumulate item is taken in the idle state and updates the frame minimum and maximum.
// A map item goes through the restoring divider in order: accept, setup, eight quotient
// steps and the output load; flat, below-minimum and saturating pixels skip the steps.
// Reset is synchronous and sets the minimum to 255 and the maximum to 0.
// A held result does not block accumulate items; a map result waits for the output register.
module linear_histogram_stretch_top (
   input logic       clock,
   input logic       reset,
   lhs_req_if.sink   req_ch,
   lhs_rsp_if.source rsp_ch
);

   lhs_pkg::lhs_cmd_type cmd;
   lhs_pkg::lhs_status_type status;

   lhs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_operation (req_ch.operation),
      .req_ready     (req_ch.ready),
      .status        (status),
      .cmd           (cmd)
   );

   lhs_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_starts_frame    (req_ch.starts_frame),
      .req_pixel           (req_ch.pixel),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_stretched_pixel (rsp_ch.stretched_pixel),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule

FILE: tb/sv/tb_linear_histogram_stretch_top.sv
module tb_linear_histogram_stretch_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0] pixel;
      logic [7:0] stretched;
   } stretch_expect_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lhs_req_if req_ch ();
   lhs_rsp_if rsp_ch ();

   linear_histogram_stretch_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [7:0]         track_min;
   logic [7:0]         track_max;
   stretch_expect_type pending_stretch[$];
   int                 error_count = 0;
   int                 items_sent = 0;
   bit                 source_idle_on = 1'b0;
   bit                 sink_idle_on = 1'b0;
   int                 source_run_left = 0;
   int                 sink_run_left = 0;
   int                 sink_hold_request = 0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.operation = lhs_pkg::OP_ACCUMULATE;
      req_ch.starts_frame = 1'b0;
      req_ch.pixel = 8'd0;
      rsp_ch.ready = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] stretch_pixel(logic [7:0] px, logic [7:0] lo, logic [7:0] hi);
      int unsigned quotient;
      if (hi <= lo) return px;
      if (px < lo) return 8'd0;
      quotient = ((int'(px) - int'(lo)) * int'(lhs_pkg::FULL_SCALE)) / (int'(hi) - int'(lo));
      if (quotient > lhs_pkg::FULL_SCALE) quotient = lhs_pkg::FULL_SCALE;
      return quotient[7:0];
   endfunction

   always @(posedge clock) begin
      stretch_expect_type entry;
      if (reset) begin
         track_min = lhs_pkg::MIN_RESET;
         track_max = lhs_pkg::MAX_RESET;
      end else if (req_ch.valid && req_ch.ready) begin
         if (req_ch.operation == lhs_pkg::OP_ACCUMULATE) begin
            if (req_ch.starts_frame) begin
               track_min = lhs_pkg::MIN_RESET;
               track_max = lhs_pkg::MAX_RESET;
            end
            if (req_ch.pixel < track_min) track_min = req_ch.pixel;
            if (req_ch.pixel > track_max) track_max = req_ch.pixel;
         end else begin
            entry.pixel = req_ch.pixel;
            entry.stretched = stretch_pixel(req_ch.pixel, track_min, track_max);
            pending_stretch.push_back(entry);
         end
      end
   end

   always @(posedge clock) begin
      stretch_expect_type entry;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_stretch.size() == 0) begin
            error_count++;
            if (error_count <= 60)
               $display("%0t: unexpected item, expected none, actual stretched_pixel %0d",
                        $time, rsp_ch.stretched_pixel);
         end else begin
            entry = pending_stretch.pop_front();
            if (rsp_ch.stretched_pixel !== entry.stretched) begin
               error_count++;
               if (error_count <= 60)
                  $display("%0t: stretched_pixel for pixel %0d expected %0d, actual %0d",
                           $time, entry.pixel, entry.stretched, rsp_ch.stretched_pixel);
            end
         end
      end
   end

   always begin : sink_ready_driver
      int burst;
      @(negedge clock);
      if (sink_hold_request > 0) begin
         burst = sink_hold_request;
         sink_hold_request = 0;
         rsp_ch.ready <= 1'b0;
         repeat (burst - 1) @(negedge clock);
      end else if (sink_idle_on && sink_run_left == 0) begin
         sink_run_left = $urandom_range(1, 24);
         burst = $urandom_range(1, 16);
         rsp_ch.ready <= 1'b0;
         repeat (burst - 1) @(negedge clock);
      end else begin
         rsp_ch.ready <= 1'b1;
         if (sink_run_left > 0) sink_run_left--;
      end
   end

   task automatic send_pixel(input logic op, input logic first, input logic [7:0] px);
      int gap;
      if (source_idle_on && source_run_left == 0) begin
         source_run_left = $urandom_range(1, 24);
         if ($urandom_range(0, 1) == 1) begin
            gap = $urandom_range(1, 16);
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      if (source_run_left > 0) source_run_left--;
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.starts_frame <= first;
      req_ch.pixel <= px;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_stretch.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_frame();
      logic [7:0] frame_px[$];
      logic [7:0] px;
      int count;
      int shape;
      int lo_px;
      int hi_px;
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      shape = $urandom_range(0, 4);
      lo_px = $urandom_range(0, 255);
      hi_px = $urandom_range(lo_px, 255);
      for (int i = 0; i < count; i++) begin
         case (shape)
            0: px = 8'($urandom_range(0, 255));
            1: px = 8'($urandom_range(lo_px, hi_px));
            2: px = 8'(lo_px);
            3: px = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
            default: px = 8'($urandom_range(lo_px, (lo_px > 252) ? 255 : lo_px + 3));
         endcase
         frame_px.push_back(px);
         send_pixel(lhs_pkg::OP_ACCUMULATE, i == 0, px);
      end
      foreach (frame_px[i])
         send_pixel(lhs_pkg::OP_MAP, $urandom_range(0, 7) == 0, frame_px[i]);
      repeat ($urandom_range(0, 3))
         send_pixel(lhs_pkg::OP_MAP, $urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 6))
         send_pixel(($urandom_range(0, 1) == 1) ? lhs_pkg::OP_MAP : lhs_pkg::OP_ACCUMULATE,
                    $urandom_range(0, 1) == 1, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_directed_cases();
      source_idle_on = 1'b1;
      sink_idle_on = 1'b1;
      // Mapping before anything was accumulated passes pixels through.
      send_pixel(lhs_pkg::OP_MAP, 1'b0, 8'd0);
      send_pixel(lhs_pkg::OP_MAP, 1'b0, 8'd255);
      send_pixel(lhs_pkg::OP_ACCUMULATE, 1'b1, 8'd50);
      send_pixel(lhs_pkg::OP_ACCUMULATE, 1'b0, 8'd200);
      send_pixel(lhs_pkg::OP_MAP, 1'b0, 8'd50);
      send_pixel(lhs_pkg::OP_MAP, 1'b0, 8'd200);
      send_pixel(lhs_pkg::OP_MAP, 1'b0, 8'd125);
      send_pixel(lhs_pkg::OP_MAP, 1'b0, 8'd0);
      send_pixel(lhs_pkg::OP_MAP, 1'b0, 8'd255);
      // The frame flag on a map item must leave the minimum and maximum alone.
      send_pixel(lhs_pkg::OP_MAP, 1'b1, 8'd100);
      send_pixel(lhs_pkg::OP_MAP, 1'b0, 8'd100);
      send_pixel(lhs_pkg::OP_ACCUMULATE, 1'b1, 8'd77);
      send_pixel(lhs_pkg::OP_ACCUMULATE, 1'b0, 8'd77);
      send_pixel(lhs_pkg::OP_MAP, 1'b0, 8'd77);
      send_pixel(lhs_pkg::OP_MAP, 1'b0, 8'd10);
      send_pixel(lhs_pkg::OP_ACCUMULATE, 1'b1, 8'd0);
      send_pixel(lhs_pkg::OP_ACCUMULATE, 1'b0, 8'd255);
      send_pixel(lhs_pkg::OP_MAP, 1'b0, 8'd0);
      send_pixel(lhs_pkg::OP_MAP, 1'b0, 8'd255);
      send_pixel(lhs_pkg::OP_MAP, 1'b0, 8'd254);
      send_pixel(lhs_pkg::OP_ACCUMULATE, 1'b1, 8'd254);
      send_pixel(lhs_pkg::OP_ACCUMULATE, 1'b0, 8'd255);
      send_pixel(lhs_pkg::OP_MAP, 1'b0, 8'd254);
      send_pixel(lhs_pkg::OP_MAP, 1'b0, 8'd255);
      send_pixel(lhs_pkg::OP_MAP, 1'b0, 8'd0);
      wait_for_results();
   endtask

   task automatic test_output_hold_off();
      source_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      send_pixel(lhs_pkg::OP_ACCUMULATE, 1'b1, 8'd20);
      send_pixel(lhs_pkg::OP_ACCUMULATE, 1'b0, 8'd180);
      sink_hold_request = 300;
      repeat (30) begin
         if ($urandom_range(0, 3) == 0)
            send_pixel(lhs_pkg::OP_ACCUMULATE, 1'b0, 8'($urandom_range(0, 255)));
         else
            send_pixel(lhs_pkg::OP_MAP, 1'b0, 8'($urandom_range(0, 255)));
      end
      wait_for_results();
   endtask

   task automatic test_random_frames();
      while (items_sent < 1330) begin
         source_idle_on = $urandom_range(0, 3) != 0;
         sink_idle_on = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 5) == 0)
            send_noise();
         else
            send_random_frame();
      end
   endtask

   task automatic test_steady_stream();
      source_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      while (items_sent < 1450) send_random_frame();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_output_hold_off();
      test_random_frames();
      test_steady_stream();
      wait_for_results();
      repeat (24) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
